/* sv/vjc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the virtual joystick conditioner.
// No dependencies; every other file of the block imports this package.

package vjc_pkg;

    // Field widths
    localparam int FRAC_BITS  = 14;
    localparam int COORD_BITS = 13;
    localparam int HALF_W     = 11;
    localparam int AXMODE_W   = 2;
    localparam int DZ_W       = 15;
    localparam int PAD_W      = 12;
    localparam int AXIS_W     = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCULAR_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTARY      = 3'd4;

    // Register reset values
    localparam logic [HALF_W-1:0]   HALF_SIZE_RST = 11'd100;
    localparam logic [AXMODE_W-1:0] AXIS_BOTH     = 2'd0;
    localparam logic [AXMODE_W-1:0] AXIS_X_ONLY   = 2'd1;
    localparam logic [AXMODE_W-1:0] AXIS_Y_ONLY   = 2'd2;
    // Spare selection, behaves as y only
    localparam logic [AXMODE_W-1:0] AXIS_SPARE    = 2'd3;

    // Largest magnitude of a normalized value, 1.0 in Q1.FRAC_BITS
    localparam int AXIS_LIMIT = 1 << FRAC_BITS;

    typedef enum logic [1:0] {
        CMD_PRESS    = 2'd0,
        CMD_MOVE     = 2'd1,
        CMD_RELEASE  = 2'd2,
        CMD_RECENTER = 2'd3
    } cmd_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PAD_W-1:0]      pad_t;
    typedef logic signed [AXIS_W-1:0]     axis_t;

endpackage

/* sv/vjc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels of the virtual joystick conditioner: pointer events in,
// conditioned pad results out. Depends on vjc_pkg.

interface vjc_event_if;
    import vjc_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   command;
    coord_t offset_x;
    coord_t offset_y;

    modport source (output valid, command, offset_x, offset_y, input ready);
    modport sink   (input valid, command, offset_x, offset_y, output ready);
endinterface

interface vjc_result_if;
    import vjc_pkg::*;

    logic  valid;
    logic  ready;
    pad_t  pad_x;
    pad_t  pad_y;
    axis_t axis_x;
    axis_t axis_y;

    modport source (output valid, pad_x, pad_y, axis_x, axis_y, input ready);
    modport sink   (input valid, pad_x, pad_y, axis_x, axis_y, output ready);
endinterface

/* sv/virtual_joystick_conditioner.sv */
`timescale 1ns / 1ps
// Top level of the virtual joystick conditioner: event sequencer, shared
// multiplier and shared subtractor. Depends on vjc_pkg and vjc_if.

// Each pointer event (press, move, release, recenter) yields one beat of pad
// offset and normalized Q1.14 axis values, except a move while released,
// which yields nothing. The offsets are clamped per axis to +-half_size, may
// be pulled back onto the circle of radius half_size and are reduced to the
// selected axes; the normalized values are zeroed inside the dead zone. When
// the circle limit is on and the point lies outside it, the four results each
// take a 32-step restoring divide and a 16-step integer square root on the
// one shared subtractor. events.ready is high only while the sequencer is
// idle; a finished beat waits in the output register, so the next event may
// be taken while the previous result is still stalled. Write configuration
// only while idle.

module virtual_joystick_conditioner (
    input  logic                           clk,
    input  logic                           rst_n,
    vjc_event_if.sink                      events,
    vjc_result_if.source                   results,
    input  logic                           cfg_write,
    input  logic [vjc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vjc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vjc_pkg::*;

    // Magnitude width of a rounded result, quotient and root widths
    localparam int K_W    = (FRAC_BITS + 1 > HALF_W) ? FRAC_BITS + 1 : HALF_W;
    localparam int Q_W    = 2 * K_W + 2;
    localparam int R_W    = Q_W / 2;
    localparam int SQ_W   = 2 * HALF_W;
    localparam int D_W    = SQ_W + 1;
    localparam int N_W    = Q_W + D_W;
    localparam int MA_W   = 2 * K_W;
    localparam int MB_W   = SQ_W;
    localparam int PW     = MA_W + MB_W;
    localparam int SUB_W  = (D_W + 1 > R_W + 3) ? D_W + 1 : R_W + 3;
    localparam int CNT_W  = $clog2(Q_W + 1);
    localparam int CW     = ((COORD_BITS > PAD_W) ? COORD_BITS : PAD_W) + 1;

    // Result slots; bit 1 marks a normalized value, bit 0 the y axis
    localparam logic [1:0] OP_PAD_X  = 2'd0;
    localparam logic [1:0] OP_AXIS_X = 2'd2;
    localparam logic [1:0] OP_AXIS_Y = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SKIP,
        ST_SQX,
        ST_SQY,
        ST_SQH,
        ST_SEL,
        ST_NUM,
        ST_LOAD,
        ST_DIV,
        ST_ROOT,
        ST_ROUND,
        ST_AXSEL,
        ST_DZX,
        ST_DZY,
        ST_DZR,
        ST_DZCMP,
        ST_DONE
    } state_t;

    // Clamp v to +-h; values equal to -h also land on -h
    function automatic pad_t clamp_axis(input coord_t v, input logic [HALF_W-1:0] h);
        logic signed [CW-1:0] vw;
        logic signed [CW-1:0] hw;
        logic signed [CW-1:0] res;
        vw = CW'(v);
        hw = CW'({1'b0, h});
        if (vw > hw)
            res = hw;
        else if (vw <= -hw)
            res = -hw;
        else
            res = vw;
        return PAD_W'(res);
    endfunction

    // Configuration registers
    logic [HALF_W-1:0]   half_size_reg;
    logic [AXMODE_W-1:0] axis_mode_reg;
    logic                circular_limit_reg;
    logic [DZ_W-1:0]     dead_zone_reg;
    logic                momentary_reg;

    // Sequencer and datapath registers
    state_t              state_reg;
    logic                pressed_reg;
    logic                x_neg_reg;
    logic                y_neg_reg;
    logic [HALF_W-1:0]   mx_reg;
    logic [HALF_W-1:0]   my_reg;
    logic [SQ_W-1:0]     sqx_reg;
    logic [SQ_W-1:0]     sqy_reg;
    logic [SQ_W-1:0]     hsq_reg;
    logic [D_W-1:0]      s_reg;
    logic [D_W-1:0]      den_reg;
    logic                circ_reg;
    logic [1:0]          op_reg;
    logic [PW-1:0]       prod_reg;
    logic [PW:0]         acc_reg;
    logic [D_W-1:0]      rem_reg;
    logic [Q_W-1:0]      dq_reg;
    logic [R_W-1:0]      root_reg;
    logic [R_W:0]        sqrem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [K_W-1:0]      mag_reg [4];

    // Output register
    logic                out_valid_reg;
    pad_t                out_pad_x_reg;
    pad_t                out_pad_y_reg;
    axis_t               out_axis_x_reg;
    axis_t               out_axis_y_reg;

    // Combinational signals
    logic [HALF_W-1:0]   h_val;
    logic                accept;
    logic                zero_point;
    coord_t              raw_x;
    coord_t              raw_y;
    pad_t                cl_x;
    pad_t                cl_y;
    logic [MA_W-1:0]     mul_a;
    logic [MB_W-1:0]     mul_b;
    logic [PW-1:0]       mul_p;
    logic [MA_W-1:0]     ksq;
    logic [SQ_W-1:0]     sq_m;
    logic [N_W-1:0]      num_load;
    logic [D_W:0]        div_r2;
    logic [R_W+2:0]      root_r2;
    logic [R_W+2:0]      root_trial;
    logic [SUB_W-1:0]    sub_a;
    logic [SUB_W-1:0]    sub_b;
    logic [SUB_W:0]      sub_d;
    logic                sub_ge;
    logic [Q_W-1:0]      rnd_val;
    logic [Q_W:0]        rnd_sum;
    logic                out_load;
    logic                use_x;
    logic                use_y;

    // ---------------------------------------------------------------
    // Configuration writes; an index beyond the list is dropped
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_size_reg      <= HALF_SIZE_RST;
            axis_mode_reg      <= AXIS_BOTH;
            circular_limit_reg <= 1'b0;
            dead_zone_reg      <= '0;
            momentary_reg      <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HALF_SIZE:      half_size_reg      <= cfg_data[HALF_W-1:0];
                REG_AXIS_MODE:      axis_mode_reg      <= cfg_data[AXMODE_W-1:0];
                REG_CIRCULAR_LIMIT: circular_limit_reg <= cfg_data[0];
                REG_DEAD_ZONE:      dead_zone_reg      <= cfg_data[DZ_W-1:0];
                REG_MOMENTARY:      momentary_reg      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // A zero radius behaves as one pixel
    assign h_val = (half_size_reg == '0) ? HALF_W'(1) : half_size_reg;

    // ---------------------------------------------------------------
    // Event intake: recenter and momentary release drop the offsets,
    // then each axis is clamped to the square frame
    // ---------------------------------------------------------------
    assign events.ready = (state_reg == ST_IDLE);
    assign accept       = events.valid && events.ready;

    assign zero_point = (events.command == CMD_RECENTER) ||
                        ((events.command == CMD_RELEASE) && momentary_reg);
    assign raw_x = zero_point ? '0 : events.offset_x;
    assign raw_y = zero_point ? '0 : events.offset_y;
    assign cl_x  = clamp_axis(raw_x, h_val);
    assign cl_y  = clamp_axis(raw_y, h_val);

    // ---------------------------------------------------------------
    // Shared multiplier: squares for the radius test and the dead zone,
    // and the 4*m^2*k^2 numerator of the circle scaling
    // ---------------------------------------------------------------
    assign ksq  = op_reg[1] ? (MA_W'(1) << (2 * FRAC_BITS)) : MA_W'(hsq_reg);
    assign sq_m = op_reg[0] ? sqy_reg : sqx_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQX:
            begin
                mul_a = MA_W'(mx_reg);
                mul_b = MB_W'(mx_reg);
            end
            ST_SQY:
            begin
                mul_a = MA_W'(my_reg);
                mul_b = MB_W'(my_reg);
            end
            ST_SQH:
            begin
                mul_a = MA_W'(h_val);
                mul_b = MB_W'(h_val);
            end
            ST_NUM:
            begin
                mul_a = ksq;
                mul_b = sq_m;
            end
            ST_DZX:
            begin
                mul_a = MA_W'(mag_reg[2]);
                mul_b = MB_W'(mag_reg[2]);
            end
            ST_DZY:
            begin
                mul_a = MA_W'(mag_reg[3]);
                mul_b = MB_W'(mag_reg[3]);
            end
            ST_DZR:
            begin
                mul_a = MA_W'(dead_zone_reg);
                mul_b = MB_W'(dead_zone_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Dividend for the divider: the circle numerator from the multiplier,
    // or the magnitude scaled by 2^(FRAC_BITS+1) for the plain case
    assign num_load = (state_reg == ST_LOAD) ?
                      N_W'({prod_reg, 2'b00}) :
                      (N_W'(op_reg[0] ? my_reg : mx_reg) << (FRAC_BITS + 1));

    // ---------------------------------------------------------------
    // Shared subtractor: one restoring divide step or one square root
    // step per cycle
    // ---------------------------------------------------------------
    assign div_r2     = {rem_reg, dq_reg[Q_W-1]};
    assign root_r2    = {sqrem_reg, dq_reg[Q_W-1 -: 2]};
    assign root_trial = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        if (state_reg == ST_ROOT)
        begin
            sub_a = SUB_W'(root_r2);
            sub_b = SUB_W'(root_trial);
        end
        else
        begin
            sub_a = SUB_W'(div_r2);
            sub_b = SUB_W'(den_reg);
        end
    end

    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[SUB_W];

    // Round half up on the doubled quotient or root
    assign rnd_val = circ_reg ? Q_W'(root_reg) : dq_reg;
    assign rnd_sum = {1'b0, rnd_val} + (Q_W + 1)'(1);

    assign use_x = (axis_mode_reg == AXIS_BOTH) || (axis_mode_reg == AXIS_X_ONLY);
    assign use_y = (axis_mode_reg != AXIS_X_ONLY);

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pressed_reg    <= 1'b0;
            x_neg_reg      <= 1'b0;
            y_neg_reg      <= 1'b0;
            mx_reg         <= '0;
            my_reg         <= '0;
            sqx_reg        <= '0;
            sqy_reg        <= '0;
            hsq_reg        <= '0;
            s_reg          <= '0;
            den_reg        <= '0;
            circ_reg       <= 1'b0;
            op_reg         <= OP_PAD_X;
            prod_reg       <= '0;
            acc_reg        <= '0;
            rem_reg        <= '0;
            dq_reg         <= '0;
            root_reg       <= '0;
            sqrem_reg      <= '0;
            cnt_reg        <= '0;
            for (int i = 0; i < 4; i++)
                mag_reg[i] <= '0;
            out_valid_reg  <= 1'b0;
            out_pad_x_reg  <= '0;
            out_pad_y_reg  <= '0;
            out_axis_x_reg <= '0;
            out_axis_y_reg <= '0;
        end
        else
        begin
            // Release the output beat once taken, unless a new one loads
            if (results.ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        x_neg_reg <= cl_x[PAD_W-1];
                        y_neg_reg <= cl_y[PAD_W-1];
                        mx_reg    <= HALF_W'(cl_x[PAD_W-1] ? -cl_x : cl_x);
                        my_reg    <= HALF_W'(cl_y[PAD_W-1] ? -cl_y : cl_y);
                        if (events.command == CMD_PRESS)
                            pressed_reg <= 1'b1;
                        else if (events.command == CMD_RELEASE)
                            pressed_reg <= 1'b0;
                        // Drop a move while the pad is released
                        if ((events.command == CMD_MOVE) && !pressed_reg)
                            state_reg <= ST_SKIP;
                        else
                            state_reg <= ST_SQX;
                    end
                end

                ST_SKIP:
                begin
                    state_reg <= ST_IDLE;
                end

                ST_SQX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQY;
                end

                ST_SQY:
                begin
                    sqx_reg   <= prod_reg[SQ_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQH;
                end

                ST_SQH:
                begin
                    sqy_reg   <= prod_reg[SQ_W-1:0];
                    s_reg     <= D_W'(sqx_reg) + D_W'(prod_reg[SQ_W-1:0]);
                    prod_reg  <= mul_p;
                    state_reg <= ST_SEL;
                end

                ST_SEL:
                begin
                    // Outside the circle: all four values go through divide
                    // and root; otherwise the pad is the clamped point
                    hsq_reg <= prod_reg[SQ_W-1:0];
                    if (circular_limit_reg && (s_reg > D_W'(prod_reg[SQ_W-1:0])))
                    begin
                        circ_reg <= 1'b1;
                        op_reg   <= OP_PAD_X;
                    end
                    else
                    begin
                        circ_reg   <= 1'b0;
                        op_reg     <= OP_AXIS_X;
                        mag_reg[0] <= K_W'(mx_reg);
                        mag_reg[1] <= K_W'(my_reg);
                    end
                    state_reg <= ST_NUM;
                end

                ST_NUM:
                begin
                    if (circ_reg)
                    begin
                        prod_reg  <= mul_p;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        rem_reg   <= num_load[N_W-1:Q_W];
                        dq_reg    <= num_load[Q_W-1:0];
                        den_reg   <= D_W'(h_val);
                        cnt_reg   <= CNT_W'(Q_W - 1);
                        state_reg <= ST_DIV;
                    end
                end

                ST_LOAD:
                begin
                    rem_reg   <= num_load[N_W-1:Q_W];
                    dq_reg    <= num_load[Q_W-1:0];
                    den_reg   <= s_reg;
                    cnt_reg   <= CNT_W'(Q_W - 1);
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    rem_reg <= sub_ge ? D_W'(sub_d) : D_W'(div_r2);
                    dq_reg  <= {dq_reg[Q_W-2:0], sub_ge};
                    if (cnt_reg == '0)
                    begin
                        if (circ_reg)
                        begin
                            root_reg  <= '0;
                            sqrem_reg <= '0;
                            cnt_reg   <= CNT_W'(R_W - 1);
                            state_reg <= ST_ROOT;
                        end
                        else
                        begin
                            state_reg <= ST_ROUND;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end

                ST_ROOT:
                begin
                    sqrem_reg <= sub_ge ? (R_W + 1)'(sub_d) : (R_W + 1)'(root_r2);
                    root_reg  <= {root_reg[R_W-2:0], sub_ge};
                    dq_reg    <= dq_reg << 2;
                    if (cnt_reg == '0)
                        state_reg <= ST_ROUND;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end

                ST_ROUND:
                begin
                    mag_reg[op_reg] <= K_W'(rnd_sum[Q_W:1]);
                    if (op_reg == OP_AXIS_Y)
                    begin
                        state_reg <= ST_AXSEL;
                    end
                    else
                    begin
                        op_reg    <= op_reg + 1'b1;
                        state_reg <= ST_NUM;
                    end
                end

                ST_AXSEL:
                begin
                    if (!use_x)
                    begin
                        mag_reg[0] <= '0;
                        mag_reg[2] <= '0;
                    end
                    if (!use_y)
                    begin
                        mag_reg[1] <= '0;
                        mag_reg[3] <= '0;
                    end
                    state_reg <= ST_DZX;
                end

                ST_DZX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_DZY;
                end

                ST_DZY:
                begin
                    acc_reg   <= {1'b0, prod_reg};
                    prod_reg  <= mul_p;
                    state_reg <= ST_DZR;
                end

                ST_DZR:
                begin
                    acc_reg   <= acc_reg + {1'b0, prod_reg};
                    prod_reg  <= mul_p;
                    state_reg <= ST_DZCMP;
                end

                ST_DZCMP:
                begin
                    // Inside the dead zone both normalized values read zero
                    if (acc_reg < {1'b0, prod_reg})
                    begin
                        mag_reg[2] <= '0;
                        mag_reg[3] <= '0;
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    // Hold here until the output register is free
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_pad_x_reg  <= x_neg_reg ? -PAD_W'(mag_reg[0]) : PAD_W'(mag_reg[0]);
                        out_pad_y_reg  <= y_neg_reg ? -PAD_W'(mag_reg[1]) : PAD_W'(mag_reg[1]);
                        out_axis_x_reg <= x_neg_reg ? -AXIS_W'(mag_reg[2]) :
                                                      AXIS_W'(mag_reg[2]);
                        // Screen y grows downward, the axis value upward
                        out_axis_y_reg <= y_neg_reg ? AXIS_W'(mag_reg[3]) :
                                                      -AXIS_W'(mag_reg[3]);
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.pad_x  = out_pad_x_reg;
    assign results.pad_y  = out_pad_y_reg;
    assign results.axis_x = out_axis_x_reg;
    assign results.axis_y = out_axis_y_reg;

endmodule

/* sv/vjc_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the virtual joystick conditioner, bound to the
// top level. Depends on vjc_pkg and virtual_joystick_conditioner.

module vjc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          ev_valid,
    input logic          ev_ready,
    input logic          res_valid,
    input logic          res_ready,
    input vjc_pkg::pad_t  pad_x,
    input vjc_pkg::pad_t  pad_y,
    input vjc_pkg::axis_t axis_x,
    input vjc_pkg::axis_t axis_y
);
    import vjc_pkg::*;

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(pad_x) && $stable(pad_y) &&
                                    $stable(axis_x) && $stable(axis_y))
        else $error("result beat changed while stalled");

    // The sequencer is busy in the cycle after taking an event
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_ready |=> !ev_ready)
        else $error("event taken while sequencer busy");

    // Normalized values stay within +-1.0 and pads never take the most negative code
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (axis_x <= AXIS_LIMIT) && (axis_x >= -AXIS_LIMIT) &&
                      (axis_y <= AXIS_LIMIT) && (axis_y >= -AXIS_LIMIT) &&
                      (pad_x != {1'b1, {(PAD_W - 1){1'b0}}}) &&
                      (pad_y != {1'b1, {(PAD_W - 1){1'b0}}}))
        else $error("result out of range");

    // A pad at the centre reports no deflection
    a_centre_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (pad_x == '0) && (pad_y == '0) |-> (axis_x == '0) && (axis_y == '0))
        else $error("centred pad with nonzero axis value");

endmodule

bind virtual_joystick_conditioner vjc_checker u_vjc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (events.valid),
    .ev_ready  (events.ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .pad_x     (results.pad_x),
    .pad_y     (results.pad_y),
    .axis_x    (results.axis_x),
    .axis_y    (results.axis_y)
);
